[sv/aph_pkg.sv]
// Shared types and constants for the angular pair histogram unit.
// No dependencies; imported by aph_dot, the top level and the testbench.
package aph_pkg;

  localparam int MAX_BINS = 64;
  localparam int BIN_W    = $clog2(MAX_BINS);
  localparam int CFG_W    = 7;
  localparam int COORD_W  = 32;
  localparam int EDGE_W   = 32;
  localparam int CNT_W    = 48;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int Q_SHIFT  = 30;
  localparam int V_W      = ACC_W - Q_SHIFT;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CFG_W-1:0] MIN_BINS = CFG_W'(2);

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_DOT,
    ST_TOP,
    ST_SCAN,
    ST_CNT_RD,
    ST_CNT_WR
  } state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [BIN_W-1:0]          bin_index;
    logic signed [EDGE_W-1:0]  edge_value;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
  } pair_req_t;

  typedef struct packed {
    logic [BIN_W-1:0] read_bin;
    logic [CNT_W-1:0] pair_total;
  } pair_res_t;

  typedef struct packed {
    logic             done;
    logic [V_W-1:0]   v;
  } dot_stat_t;

endpackage

[sv/aph_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Read data holds while no read is issued. No dependencies.
module aph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/aph_dot.sv]
// Dot product unit: one shared 32x32 multiplier for all three products and a
// 66-bit accumulator; result floor-shifted by Q_SHIFT. Depends on aph_pkg.
module aph_dot import aph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  pair_req_t req_i,
  output dot_stat_t stat_o
);

  logic signed [COORD_W-1:0] a_q [3];
  logic signed [COORD_W-1:0] b_q [3];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  mul;
  logic [1:0]                step_q;
  logic                      run_q;

  assign mul = (step_q == 2'd3) ? $signed(PROD_W'(0)) : a_q[step_q] * b_q[step_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + 2'd1;
      if (step_q == 2'd3) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q[0] <= req_i.ax;
      a_q[1] <= req_i.ay;
      a_q[2] <= req_i.az;
      b_q[0] <= req_i.bx;
      b_q[1] <= req_i.by;
      b_q[2] <= req_i.bz;
      acc_q  <= '0;
    end else if (run_q) begin
      prod_q <= mul;
      if (step_q != 2'd0) begin
        acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
      end
    end
  end

  assign stat_o.done = run_q && (step_q == 2'd3);
  assign stat_o.v    = acc_q[ACC_W-1:Q_SHIFT];

endmodule

[sv/angular_pair_histogram_unit.sv]
// Top level of the angular pair histogram: sequencer, edge and count RAMs.
// Depends on aph_pkg, aph_ram and aph_dot.
//
// Usage: transactions enter on in_valid_i/in_stall_o/in_data_i and results
// leave on out_valid_o/out_stall_i/out_data_o. Only a read transaction gives
// a result. Configuration is a single register, bin count in use, written by
// cfg_we_i/cfg_wdata_i; the user must write it only while the block is idle,
// which the block itself does not enforce. One transaction is processed at
// a time; in_stall_o is high while busy.
//   load edge, clear counts: done at accept, the block stays idle.
//   read bin: the result register loads in ST_RD_WAIT once it is free.
//   count pair: dot product on the shared multiplier, top-edge check that may
//   reject, else linear edge RAM scan, one entry per cycle, then count update.
// Reset clears all counts at once through per-bin valid bits, sets the bin
// count to 2 and empties the output register; edges are undefined until
// loaded. When the receiver stalls, the result stays in the output register;
// a further read then waits until that register is free and stalls all input.
module angular_pair_histogram_unit import aph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pair_req_t        in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pair_res_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [CFG_W-1:0] n_used, n_m1;
  logic [BIN_W-1:0] n_last;
  logic             in_acc, out_free;
  logic             out_valid_q;
  pair_res_t        out_q;
  logic [MAX_BINS-1:0] valid_q;
  logic [BIN_W-1:0] scan_q, scan_d, bin_q, bin_d, rd_idx_q;
  logic signed [EDGE_W-1:0] edge0_q;

  logic             edge_we, edge_re;
  logic [BIN_W-1:0] edge_raddr;
  logic [EDGE_W-1:0] edge_rdata;
  logic             cnt_we, cnt_re;
  logic [BIN_W-1:0] cnt_raddr;
  logic [CNT_W-1:0] cnt_rdata, cnt_cur, cnt_wdata;
  logic             dot_start;
  dot_stat_t        dot_stat;

  logic signed [V_W-1:0] v_s;
  logic signed [V_W-1:0] edge_ext, edge0_ext;
  logic             match, reject;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    priority if (cfg_q < MIN_BINS) begin
      n_used = MIN_BINS;
    end else if (cfg_q > CFG_W'(MAX_BINS)) begin
      n_used = CFG_W'(MAX_BINS);
    end else begin
      n_used = cfg_q;
    end
  end
  assign n_m1   = n_used - CFG_W'(1);
  assign n_last = n_m1[BIN_W-1:0];

  assign v_s       = dot_stat.v;
  assign edge_ext  = {{(V_W-EDGE_W){edge_rdata[EDGE_W-1]}}, edge_rdata};
  assign edge0_ext = {{(V_W-EDGE_W){edge0_q[EDGE_W-1]}}, edge0_q};
  assign match     = (v_s <= edge_ext);
  assign reject    = (v_s > edge0_ext) || match;

  assign cnt_cur   = valid_q[bin_q] ? cnt_rdata : '0;
  assign cnt_wdata = cnt_cur + CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.kind)
            KIND_PAIR:  state_d = ST_DOT;
            KIND_READ:  state_d = ST_RD_WAIT;
            KIND_LOAD:  state_d = ST_IDLE;
            KIND_CLEAR: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DOT: begin
        if (dot_stat.done) state_d = ST_TOP;
      end
      ST_TOP: begin
        priority if (reject) begin
          state_d = ST_IDLE;
        end else if (scan_q == BIN_W'(1)) begin
          state_d = ST_CNT_RD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || scan_q == BIN_W'(1)) state_d = ST_CNT_RD;
      end
      ST_CNT_RD: state_d = ST_CNT_WR;
      ST_CNT_WR: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_raddr = scan_q - BIN_W'(1);
    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    cnt_raddr  = bin_q;
    dot_start  = 1'b0;
    scan_d     = scan_q;
    bin_d      = bin_q;
    unique case (state_q)
      ST_IDLE: begin
        edge_we   = in_acc && (in_data_i.kind == KIND_LOAD);
        dot_start = in_acc && (in_data_i.kind == KIND_PAIR);
        cnt_re    = in_acc && (in_data_i.kind == KIND_READ);
        cnt_raddr = in_data_i.bin_index;
      end
      ST_DOT: begin
        if (dot_stat.done) begin
          edge_re    = 1'b1;
          edge_raddr = n_last;
          scan_d     = n_last;
        end
      end
      ST_TOP: begin
        if (!reject) begin
          if (scan_q == BIN_W'(1)) begin
            bin_d = BIN_W'(1);
          end else begin
            edge_re = 1'b1;
            scan_d  = scan_q - BIN_W'(1);
          end
        end
      end
      ST_SCAN: begin
        priority if (match) begin
          bin_d = scan_q + BIN_W'(1);
        end else if (scan_q == BIN_W'(1)) begin
          bin_d = BIN_W'(1);
        end else begin
          edge_re = 1'b1;
          scan_d  = scan_q - BIN_W'(1);
        end
      end
      ST_CNT_RD: cnt_re = 1'b1;
      ST_CNT_WR: cnt_we = (cnt_cur != CNT_MAX);
      ST_RD_WAIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= MIN_BINS;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (state_q == ST_RD_WAIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && in_data_i.kind == KIND_CLEAR) begin
        valid_q <= '0;
      end else if (state_q == ST_CNT_WR) begin
        valid_q[bin_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    bin_q  <= bin_d;
    if (in_acc && in_data_i.kind == KIND_READ) begin
      rd_idx_q <= in_data_i.bin_index;
    end
    if (edge_we && in_data_i.bin_index == '0) begin
      edge0_q <= in_data_i.edge_value;
    end
    if (state_q == ST_RD_WAIT && out_free) begin
      out_q.read_bin   <= rd_idx_q;
      out_q.pair_total <= valid_q[rd_idx_q] ? cnt_rdata : '0;
    end
  end

  aph_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dot_start),
    .req_i   (in_data_i),
    .stat_o  (dot_stat)
  );

  aph_ram #(
    .WIDTH (EDGE_W),
    .DEPTH (MAX_BINS)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (in_data_i.bin_index),
    .wdata_i (in_data_i.edge_value),
    .re_i    (edge_re),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  aph_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BINS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (bin_q),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  a_dot_done_in_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_stat.done |-> state_q == ST_DOT)
    else $error("dot product finished outside the dot state");

  a_bin_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CNT_RD |-> (bin_q != '0) && ({1'b0, bin_q} < n_used))
    else $error("selected bin outside the bins in use");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> (scan_q != '0) && ({1'b0, scan_q} < n_m1))
    else $error("edge scan address out of range");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RD_WAIT)
    else $error("result produced without a read");

endmodule

[sim/tb_angular_pair_histogram_unit.sv]
// Testbench for angular_pair_histogram_unit: directed and random transactions with
// a built-in predictor of the edge and count tables and a scoreboard on read results.
// Depends on aph_pkg and the RTL of the block only.
module tb_angular_pair_histogram_unit;
  import aph_pkg::*;

  localparam int SETTLE_CYCLES = MAX_BINS + 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 170;
  localparam int NUM_PHASES    = 9;
  localparam logic signed [COORD_W-1:0] Q_ONE     = 32'sh4000_0000;
  localparam logic signed [COORD_W-1:0] Q_NEG_ONE = 32'shC000_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN     = 32'sh8000_0000;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  pair_req_t        in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  pair_res_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // predictor state
  logic signed [EDGE_W-1:0] edge_mem  [MAX_BINS];
  logic [CNT_W-1:0]         tally_mem [MAX_BINS];
  logic [CFG_W-1:0]         bins_cfg = CFG_W'(2);
  pair_res_t                read_totals_q [$];

  int mismatches = 0;
  bit quiet      = 1'b0;
  int hold_len   = 0;
  bit holding    = 1'b0;

  angular_pair_histogram_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int bins_in_use();
    if (bins_cfg < MIN_BINS) return int'(MIN_BINS);
    if (bins_cfg > MAX_BINS) return MAX_BINS;
    return int'(bins_cfg);
  endfunction

  // evenly spaced cosine edges from 1.0 down to -1.0 over n entries
  function automatic logic signed [EDGE_W-1:0] ladder_edge(input int idx, input int n);
    longint stride;
    stride = (64'sd1 << 31) / (n - 1);
    if (idx >= n - 1) return Q_NEG_ONE;
    return EDGE_W'(64'sd1073741824 - longint'(idx) * stride);
  endfunction

  function automatic logic signed [COORD_W-1:0] q30_rand(input int unsigned span);
    return COORD_W'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  function automatic pair_req_t noise_request();
    logic [255:0] raw;
    for (int k = 0; k < 8; k++) raw[k*32 +: 32] = $urandom;
    return pair_req_t'(raw[$bits(pair_req_t)-1:0]);
  endfunction

  function automatic pair_req_t make_pair(input logic signed [COORD_W-1:0] ax, ay, az,
                                          input logic signed [COORD_W-1:0] bx, by, bz);
    pair_req_t req;
    req = noise_request();
    req.kind = KIND_PAIR;
    req.ax = ax; req.ay = ay; req.az = az;
    req.bx = bx; req.by = by; req.bz = bz;
    return req;
  endfunction

  function automatic pair_req_t make_load(input int idx, input logic signed [EDGE_W-1:0] val);
    pair_req_t req;
    req = noise_request();
    req.kind = KIND_LOAD;
    req.bin_index = BIN_W'(idx);
    req.edge_value = val;
    return req;
  endfunction

  function automatic pair_req_t make_read(input int idx);
    pair_req_t req;
    req = noise_request();
    req.kind = KIND_READ;
    req.bin_index = BIN_W'(idx);
    return req;
  endfunction

  function automatic pair_req_t make_clear();
    pair_req_t req;
    req = noise_request();
    req.kind = KIND_CLEAR;
    return req;
  endfunction

  function automatic void predict_request(input pair_req_t req);
    int n;
    bit hit;
    logic signed [ACC_W-1:0] dot, v, e_top, e_low, e_cut;
    pair_res_t res;
    case (req.kind)
      KIND_LOAD: edge_mem[req.bin_index] = req.edge_value;
      KIND_PAIR: begin
        n = bins_in_use();
        dot = ACC_W'(req.ax) * ACC_W'(req.bx) + ACC_W'(req.ay) * ACC_W'(req.by)
            + ACC_W'(req.az) * ACC_W'(req.bz);
        v = dot >>> Q_SHIFT;
        e_top = edge_mem[0];
        e_low = edge_mem[n - 1];
        hit = 1'b0;
        if (v <= e_top && v > e_low) begin
          for (int i = n - 1; i >= 1 && !hit; i--) begin
            e_cut = edge_mem[i - 1];
            if (v <= e_cut) begin
              hit = 1'b1;
              if (tally_mem[i] != CNT_MAX) tally_mem[i] = tally_mem[i] + 1'b1;
            end
          end
        end
      end
      KIND_READ: begin
        res.read_bin = req.bin_index;
        res.pair_total = tally_mem[req.bin_index];
        read_totals_q.push_back(res);
      end
      default: for (int i = 0; i < MAX_BINS; i++) tally_mem[i] = '0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_request(input pair_req_t req);
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // drop valid, wait for every pending read, then let a worst-case pair scan finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (read_totals_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bin_count(input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    bins_cfg = val;
  endtask

  function automatic pair_req_t random_request();
    pair_req_t req;
    int unsigned pick, shape;
    int n;
    n = bins_in_use();
    req = noise_request();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      req.kind = KIND_PAIR;
      shape = $urandom_range(0, 9);
      if (shape < 6) begin
        // nearly aligned with x: the dot product sweeps all bins
        req.ax = Q_ONE - COORD_W'($urandom_range(0, 1 << 16));
        if ($urandom_range(0, 1) == 1) req.ax = -req.ax;
        req.ay = q30_rand(1 << 14);
        req.az = q30_rand(1 << 14);
        req.bx = q30_rand(1 << 30);
        req.by = q30_rand(1 << 14);
        req.bz = q30_rand(1 << 14);
      end else if (shape < 7) begin
        // lands on an edge or one step either side of it
        req.ax = Q_ONE;
        req.ay = '0;
        req.az = '0;
        req.by = '0;
        req.bz = '0;
        req.bx = COORD_W'(longint'(ladder_edge($urandom_range(0, n - 1), n))
                          + longint'($urandom_range(0, 2)) - 1);
      end else if (shape < 9) begin
        req.ax = q30_rand(1 << 30);
        req.ay = q30_rand(1 << 30);
        req.az = q30_rand(1 << 30);
        req.bx = q30_rand(1 << 30);
        req.by = q30_rand(1 << 30);
        req.bz = q30_rand(1 << 30);
      end
    end else if (pick < 85) begin
      req.kind = KIND_READ;
    end else if (pick < 97) begin
      req.kind = KIND_LOAD;
      if ($urandom_range(0, 2) != 0) req.edge_value = ladder_edge(req.bin_index, n);
    end else begin
      req.kind = KIND_CLEAR;
    end
    return req;
  endfunction

  task automatic test_reset_counts();
    send_request(make_read(0));
    send_request(make_read(MAX_BINS - 1));
    send_request(make_read($urandom_range(1, MAX_BINS - 2)));
  endtask

  // default of two bins in use: one bin between 1.0 and -1.0
  task automatic test_pair_extremes();
    for (int i = 0; i < MAX_BINS; i++) send_request(make_load(i, ladder_edge(i, MAX_BINS)));
    send_request(make_load(0, Q_ONE));
    send_request(make_load(1, Q_NEG_ONE));
    send_request(make_pair(Q_ONE, 0, 0, Q_ONE, 0, 0));
    send_request(make_pair(Q_ONE, 0, 0, Q_NEG_ONE, 0, 0));
    send_request(make_pair(Q_ONE, 0, 0, Q_NEG_ONE + 1, 0, 0));
    send_request(make_pair(0, Q_ONE, 0, Q_ONE, 0, 0));
    send_request(make_pair(1, 0, 0, -1, 0, 0));
    send_request(make_pair(Q_ONE, Q_ONE, 0, Q_ONE, 1, 0));
    send_request(make_pair(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_request(make_pair(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_request(make_pair(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
    send_request(make_read(0));
    send_request(make_read(1));
    send_request(make_read(MAX_BINS - 1));
  endtask

  task automatic test_unordered_edges();
    wait_idle();
    write_bin_count(CFG_W'(4));
    send_request(make_load(0, Q_ONE));
    send_request(make_load(1, 32'shE000_0000));
    send_request(make_load(2, 32'sh2000_0000));
    send_request(make_load(3, Q_NEG_ONE));
    send_request(make_pair(Q_ONE, 0, 0, 32'sh1000_0000, 0, 0));
    send_request(make_pair(Q_ONE, 0, 0, 32'sh2000_0005, 0, 0));
    send_request(make_pair(Q_ONE, 0, 0, 32'shD000_0000, 0, 0));
    for (int i = 1; i < 4; i++) send_request(make_read(i));
  endtask

  task automatic test_clear_counts();
    send_request(make_clear());
    send_request(make_read(1));
    send_request(make_read(3));
    send_request(make_pair(Q_ONE, 0, 0, 32'sh1000_0000, 0, 0));
    send_request(make_read(3));
  endtask

  // receiver holds off while reads keep coming, so the input side backs up
  task automatic test_output_backpressure();
    wait_idle();
    hold_len = HOLD_CYCLES;
    while (!holding) @(posedge clk);
    for (int k = 0; k < 24; k++) begin
      if (k % 3 == 0) send_request(make_pair(Q_ONE, 0, 0, q30_rand(1 << 30), 0, 0));
      else send_request(make_read($urandom_range(0, MAX_BINS - 1)));
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    int unsigned settings [NUM_PHASES];
    int n;
    settings = '{64, 0, 1, 127, 65, 2, 33, 3, 3};
    settings[NUM_PHASES - 2] = $urandom_range(3, MAX_BINS - 1);
    settings[NUM_PHASES - 1] = $urandom_range(0, 127);
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      quiet = (p == NUM_PHASES - 1);
      write_bin_count(CFG_W'(settings[p]));
      n = bins_in_use();
      for (int i = 0; i < n; i++) send_request(make_load(i, ladder_edge(i, n)));
      for (int k = 0; k < PHASE_ITEMS; k++) send_request(random_request());
    end
  endtask

  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        holding = 1'b1;
        for (held = 0; held < hold_len; held++) @(posedge clk);
        out_stall <= 1'b0;
        hold_len = 0;
        holding = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    pair_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (read_totals_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction bin %0d total %0d",
                                out_data.read_bin, out_data.pair_total));
      end else begin
        want = read_totals_q.pop_front();
        if (out_data.read_bin !== want.read_bin)
          flag_mismatch($sformatf("read_bin exp %0d got %0d", want.read_bin,
                                  out_data.read_bin));
        if (out_data.pair_total !== want.pair_total)
          flag_mismatch($sformatf("pair_total bin %0d exp %0d got %0d", want.read_bin,
                                  want.pair_total, out_data.pair_total));
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_BINS; i++) tally_mem[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_counts();
    test_pair_extremes();
    test_unordered_edges();
    test_clear_counts();
    test_output_backpressure();
    test_random_phases();
    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
